>>> hdl/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and microcode for the seeded dice roller
// Request kinds, sequencer control word, control program and die-side table.
// ----------------------------------------------------------------------------
package sdr_pkg;

	localparam int unsigned DataW    = 16;
	localparam int unsigned PcW      = 3;
	localparam int unsigned DivSteps = DataW;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	typedef enum logic [2:0] {
		KIND_DRAW     = 3'd0,
		KIND_RANGE    = 3'd1,
		KIND_DICE     = 3'd2,
		KIND_TEMPLATE = 3'd3,
		KIND_LOAD     = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_ALWAYS,
		JMP_REQ,
		JMP_DONE,
		JMP_DIV,
		JMP_OUT
	} jmp_t;

	typedef struct packed {
		jmp_t           jmp;
		logic [PcW-1:0] target;
		logic           accept;
		logic           mix;
		logic           div_step;
		logic           add;
		logic           emit;
	} uop_t;

	localparam logic [PcW-1:0] ADDR_FETCH = 3'd0;
	localparam logic [PcW-1:0] ADDR_CHECK = 3'd1;
	localparam logic [PcW-1:0] ADDR_MIX   = 3'd2;
	localparam logic [PcW-1:0] ADDR_DIV   = 3'd3;
	localparam logic [PcW-1:0] ADDR_ACC   = 3'd4;
	localparam logic [PcW-1:0] ADDR_EMIT  = 3'd5;

	localparam logic [DataW-1:0] TplCountMask = 16'hf000;
	localparam logic [DataW-1:0] TplCodeMask  = 16'h0f00;
	localparam logic [DataW-1:0] TplOffMask   = 16'h00ff;

	function automatic uop_t ucode(input logic [PcW-1:0] addr);
		uop_t u;
		u = '{jmp: JMP_ALWAYS, target: ADDR_FETCH, default: 1'b0};
		unique case (addr)
			ADDR_FETCH: begin
				u.jmp    = JMP_REQ;
				u.target = ADDR_EMIT;
				u.accept = 1'b1;
			end
			ADDR_CHECK: begin
				u.jmp    = JMP_DONE;
				u.target = ADDR_EMIT;
			end
			ADDR_MIX: begin
				u.jmp = JMP_NEXT;
				u.mix = 1'b1;
			end
			ADDR_DIV: begin
				u.jmp      = JMP_DIV;
				u.target   = ADDR_DIV;
				u.div_step = 1'b1;
			end
			ADDR_ACC: begin
				u.jmp    = JMP_ALWAYS;
				u.target = ADDR_CHECK;
				u.add    = 1'b1;
			end
			ADDR_EMIT: begin
				u.jmp    = JMP_OUT;
				u.target = ADDR_FETCH;
				u.emit   = 1'b1;
			end
			default: begin
				u.jmp    = JMP_ALWAYS;
				u.target = ADDR_FETCH;
			end
		endcase
		return u;
	endfunction

	function automatic logic [DataW-1:0] tpl_sides(input logic [3:0] code);
		logic [DataW-1:0] s;
		case (code)
			4'd1:    s = 16'd6;
			4'd2:    s = 16'd20;
			4'd3:    s = 16'd3;
			default: s = 16'd4;
		endcase
		return s;
	endfunction

	function automatic logic [DataW-1:0] rotl(input logic [DataW-1:0] v, input int unsigned k);
		return (v << k) | (v >> (DataW - k));
	endfunction

endpackage

>>> hdl/seeded_dice_roller.sv
// ----------------------------------------------------------------------------
// seeded_dice_roller: seeded 16-bit draw and dice generator
// A seed load or an unknown kind goes from fetch straight to emit; a roll
// of N dice (a draw is one die) loops once per die, then emits the total.
// Each die costs mix, 16 steps of the shared restoring remainder, accumulate.
// Throughput: one request at a time; the next is taken once the result sits
// in the output register. Reset clears both seeds, idles the sequencer.
// ----------------------------------------------------------------------------
module seeded_dice_roller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         kind,
	input  logic [15:0]        word_a,
	input  logic [15:0]        word_b,
	input  logic signed [15:0] offset,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [15:0]        value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	localparam int unsigned W = sdr_pkg::DataW;

	logic [sdr_pkg::PcW-1:0]     pc_q;
	logic [sdr_pkg::PcW-1:0]     pc_next;
	sdr_pkg::uop_t               uw;
	logic [W-1:0]                seed_q;
	logic [W-1:0]                tseed_q;
	logic [W-1:0]                cnt_q;
	logic [W-1:0]                dmag_q;
	logic                        mod_zero_q;
	logic [W-1:0]                acc_q;
	logic [W-1:0]                dq_q;
	logic [W-1:0]                rem_q;
	logic                        neg_q;
	logic [sdr_pkg::DivCntW-1:0] div_cnt_q;
	logic                        rsp_valid_q;
	logic [W-1:0]                value_q;

	logic         fire;
	logic         is_roll;
	logic         done;
	logic         out_free;
	logic [W-1:0] modv;
	logic [W-1:0] cntv;
	logic [W-1:0] basev;
	logic [W-1:0] mix_a;
	logic [W-1:0] mix_b;
	logic [W-1:0] mix_c;
	logic [W-1:0] mag;
	logic [W:0]   trial;
	logic [W:0]   diff;
	logic [W-1:0] rem_signed;

	assign uw        = sdr_pkg::ucode(pc_q);
	assign req_stall = !uw.accept;
	assign cfg_ready = uw.accept;
	assign fire      = req_valid && uw.accept;
	assign done      = (cnt_q == '0) || mod_zero_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;

	always_comb begin
		is_roll = 1'b1;
		modv    = '0;
		cntv    = '0;
		basev   = '0;
		case (sdr_pkg::kind_t'(kind))
			sdr_pkg::KIND_DRAW: begin
				modv = word_a;
				cntv = W'(1);
			end
			sdr_pkg::KIND_RANGE: begin
				modv  = word_b - word_a + W'(1);
				cntv  = W'(1);
				basev = word_a - W'(1);
			end
			sdr_pkg::KIND_DICE: begin
				modv  = word_b;
				cntv  = word_a;
				basev = $unsigned(offset);
			end
			sdr_pkg::KIND_TEMPLATE: begin
				modv  = sdr_pkg::tpl_sides(4'((word_a & sdr_pkg::TplCodeMask) >> 8));
				cntv  = (word_a & sdr_pkg::TplCountMask) >> 12;
				basev = {{(W-8){word_a[7]}}, 8'(word_a & sdr_pkg::TplOffMask)};
			end
			sdr_pkg::KIND_LOAD: begin
				is_roll = 1'b0;
				basev   = word_a;
			end
			default: begin
				is_roll = 1'b0;
			end
		endcase
	end

	always_comb begin
		mix_a      = sdr_pkg::rotl(seed_q ^ tseed_q, 2);
		mix_b      = mix_a + tseed_q;
		mix_c      = sdr_pkg::rotl(mix_b ^ seed_q, 3);
		mag        = mix_c[W-1] ? (W'(0) - mix_c) : mix_c;
		trial      = {rem_q, dq_q[W-1]};
		diff       = trial - {1'b0, dmag_q};
		rem_signed = neg_q ? (W'(0) - rem_q) : rem_q;
	end

	always_comb begin
		pc_next = pc_q + sdr_pkg::PcW'(1);
		case (uw.jmp)
			sdr_pkg::JMP_NEXT:   pc_next = pc_q + sdr_pkg::PcW'(1);
			sdr_pkg::JMP_ALWAYS: pc_next = uw.target;
			sdr_pkg::JMP_REQ:    pc_next = !fire ? pc_q :
			                               (is_roll ? pc_q + sdr_pkg::PcW'(1) : uw.target);
			sdr_pkg::JMP_DONE:   pc_next = done ? uw.target : pc_q + sdr_pkg::PcW'(1);
			sdr_pkg::JMP_DIV:    pc_next = (div_cnt_q != '0) ? uw.target
			                                                 : pc_q + sdr_pkg::PcW'(1);
			sdr_pkg::JMP_OUT:    pc_next = out_free ? uw.target : pc_q;
			default:             pc_next = sdr_pkg::ADDR_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= sdr_pkg::ADDR_FETCH;
			seed_q      <= '0;
			tseed_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (cfg_valid && cfg_ready) begin
				tseed_q <= cfg_data;
			end
			if (fire && (sdr_pkg::kind_t'(kind) == sdr_pkg::KIND_LOAD)) begin
				seed_q <= word_a;
			end
			if (uw.mix) begin
				seed_q <= mag + W'(1);
			end
			if (uw.emit && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cnt_q      <= cntv;
			dmag_q     <= modv[W-1] ? (W'(0) - modv) : modv;
			mod_zero_q <= (modv == '0);
			acc_q      <= basev;
		end
		if (uw.mix) begin
			cnt_q     <= cnt_q - W'(1);
			dq_q      <= mag;
			rem_q     <= '0;
			neg_q     <= mag[W-1];
			div_cnt_q <= sdr_pkg::DivCntW'(sdr_pkg::DivSteps - 1);
		end
		if (uw.div_step) begin
			dq_q      <= dq_q << 1;
			rem_q     <= diff[W] ? trial[W-1:0] : diff[W-1:0];
			div_cnt_q <= div_cnt_q - sdr_pkg::DivCntW'(1);
		end
		if (uw.add) begin
			acc_q <= acc_q + rem_signed + W'(1);
		end
		if (uw.emit && out_free) begin
			value_q <= acc_q;
		end
	end

	a_seed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!uw.mix && !fire) |=> $stable(seed_q))
		else $error("seed changed outside a draw or a load");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(pc_q) == sdr_pkg::ADDR_EMIT))
		else $error("result raised outside the emit step");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == sdr_pkg::ADDR_ACC) |-> (rem_q < dmag_q))
		else $error("remainder not below modulus magnitude");

	a_no_stall_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(value_q)))
		else $error("stalled result lost or changed");

endmodule

>>> sim/tb_seeded_dice_roller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seeded_dice_roller: self-checking bench for the seeded dice roller
// Drives draws, interval draws, dice and template rolls, seed loads and
// unknown kinds under several second-seed settings, with random idle bursts
// on both sides. A scoreboard predicts every value from its own copy of the
// two seeds and compares each returned value in order.
// ----------------------------------------------------------------------------
module tb_seeded_dice_roller;

	localparam int unsigned QuietLimit = 200000;
	localparam logic [3:0]  SideCode6  = 4'd1;
	localparam logic [3:0]  SideCode20 = 4'd2;
	localparam logic [3:0]  SideCode3  = 4'd3;

	class roll_scoreboard;
		logic [15:0] second_seed;
		logic [15:0] seed;
		logic [15:0] expected_values[$];
		int          errors;

		function new();
			second_seed = '0;
			seed        = '0;
			errors      = 0;
		endfunction

		function logic [15:0] mix(logic [15:0] s, logic [15:0] t);
			logic [15:0] x;
			x = s ^ t;
			x = {x[13:0], x[15:14]};
			x = x + t;
			x = x ^ s;
			return {x[12:0], x[15:13]};
		endfunction

		function logic [15:0] draw(logic [15:0] modulus);
			logic [15:0] a;
			logic [15:0] mag;
			int          rem;
			if (modulus == 16'd0)
				return 16'd0;
			a    = mix(seed, second_seed);
			mag  = a[15] ? (~a + 16'd1) : a;
			seed = mag + 16'd1;
			rem  = int'($signed(mag)) % int'($signed(modulus));
			return 16'(rem + 1);
		endfunction

		function logic [15:0] roll(logic [15:0] count, logic [15:0] sides, logic [15:0] add);
			logic [15:0] sum;
			sum = '0;
			for (int i = 0; i < int'(count); i++)
				sum = sum + draw(sides);
			return sum + add;
		endfunction

		function void note_request(logic [2:0] k, logic [15:0] a, logic [15:0] b,
			logic [15:0] off);
			logic [15:0] res;
			logic [15:0] sides;
			res = '0;
			case (k)
				sdr_pkg::KIND_DRAW: res = draw(a);
				sdr_pkg::KIND_RANGE: res = a + draw(b - a + 16'd1) - 16'd1;
				sdr_pkg::KIND_DICE: res = roll(a, b, off);
				sdr_pkg::KIND_TEMPLATE: begin
					case (a[11:8])
						SideCode6:  sides = 16'd6;
						SideCode20: sides = 16'd20;
						SideCode3:  sides = 16'd3;
						default:    sides = 16'd4;
					endcase
					res = roll({12'd0, a[15:12]}, sides, {{8{a[7]}}, a[7:0]});
				end
				sdr_pkg::KIND_LOAD: begin
					seed = a;
					res  = a;
				end
				default: res = '0;
			endcase
			expected_values.push_back(res);
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_value(logic [15:0] got);
			logic [15:0] want;
			if (expected_values.size() == 0) begin
				report($sformatf("unexpected value %h", got));
			end else begin
				want = expected_values.pop_front();
				if (got !== want)
					report($sformatf("value %h, predicted %h", got, want));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [2:0]         kind      = '0;
	logic [15:0]        word_a    = '0;
	logic [15:0]        word_b    = '0;
	logic signed [15:0] offset    = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [15:0]        value;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_data  = '0;

	roll_scoreboard sb = new();
	bit             req_idle_on = 1'b0;
	bit             rsp_idle_on = 1'b0;
	int             rsp_burst   = 0;
	int             quiet_cycles = 0;

	seeded_dice_roller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.word_a    (word_a),
		.word_b    (word_b),
		.offset    (offset),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// stall the result side in bursts
	always @(posedge clk) begin
		if (rsp_burst > 0) begin
			rsp_burst <= rsp_burst - 1;
			rsp_stall <= 1'b1;
		end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
			rsp_burst <= $urandom_range(0, 9);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (req_valid && !req_stall)
			sb.note_request(kind, word_a, word_b, offset);
		if (rsp_valid && !rsp_stall)
			sb.check_value(value);
		if (cfg_valid && cfg_ready)
			sb.second_seed = cfg_data;
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task send_request(logic [2:0] k, logic [15:0] a, logic [15:0] b, logic [15:0] off);
		if (req_idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		word_a    <= a;
		word_b    <= b;
		offset    <= off;
		do @(posedge clk); while (req_stall);
	endtask

	task drain();
		req_valid <= 1'b0;
		while (sb.expected_values.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_second_seed(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task send_random();
		int          r;
		logic [2:0]  k;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] off;
		r   = $urandom_range(0, 99);
		a   = 16'($urandom);
		b   = 16'($urandom);
		off = 16'($urandom);
		if (r < 25) begin
			k = sdr_pkg::KIND_DRAW;
			case ($urandom_range(0, 9))
				0:       a = 16'h0000;
				1:       a = 16'h8000;
				2, 3, 4: a = 16'($urandom_range(1, 100));
				default: ;
			endcase
		end else if (r < 45) begin
			k = sdr_pkg::KIND_RANGE;
			if ($urandom_range(0, 2) != 0)
				b = a + 16'($urandom_range(0, 200));
		end else if (r < 65) begin
			k = sdr_pkg::KIND_DICE;
			a = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(13, 200))
				: 16'($urandom_range(0, 12));
			case ($urandom_range(0, 7))
				0:       b = 16'h0000;
				1, 2:    ;
				default: b = 16'($urandom_range(1, 30));
			endcase
		end else if (r < 85) begin
			k = sdr_pkg::KIND_TEMPLATE;
		end else if (r < 95) begin
			k = sdr_pkg::KIND_LOAD;
		end else begin
			k = 3'($urandom_range(sdr_pkg::KIND_LOAD + 1, sdr_pkg::KIND_LOAD + 3));
		end
		send_request(k, a, b, off);
	endtask

	initial begin
		logic [15:0] pivot_second;
		logic [15:0] pivot_seed;
		bit          found;
		logic [15:0] phase_seed[6];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_second_seed(16'h0000);
		req_idle_on = 1'b1;
		rsp_idle_on = 1'b1;
		send_request(sdr_pkg::KIND_DRAW,     16'h0005, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DRAW,     16'h0000, 16'hFFFF, 16'hFFFF);
		send_request(sdr_pkg::KIND_DRAW,     16'h7FFF, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DRAW,     16'h8000, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DRAW,     16'hFFFF, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DRAW,     16'h0001, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_LOAD,     16'hFFFF, 16'hFFFF, 16'h7FFF);
		send_request(sdr_pkg::KIND_RANGE,    16'd10,   16'd20,   16'h0000);
		send_request(sdr_pkg::KIND_RANGE,    16'd300,  16'd300,  16'h0000);
		send_request(sdr_pkg::KIND_RANGE,    16'd500,  16'd20,   16'h0000);
		send_request(sdr_pkg::KIND_RANGE,    16'h0000, 16'hFFFF, 16'h0000);
		send_request(sdr_pkg::KIND_LOAD,     16'h8000, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DICE,     16'd0,    16'd6,    16'h8000);
		send_request(sdr_pkg::KIND_DICE,     16'd3,    16'd6,    16'h7FFF);
		send_request(sdr_pkg::KIND_DICE,     16'd4,    16'h0000, 16'h0003);
		send_request(sdr_pkg::KIND_DICE,     16'd5,    16'hFFFB, 16'hFFFF);
		send_request(sdr_pkg::KIND_DICE,     16'd2048, 16'h7FFF, 16'h1234);
		send_request(sdr_pkg::KIND_TEMPLATE, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_request(sdr_pkg::KIND_TEMPLATE, 16'hF1FF, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_TEMPLATE, 16'h2280, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_TEMPLATE, 16'h337F, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_TEMPLATE, 16'hFF80, 16'h0000, 16'h0000);
		send_request(3'(sdr_pkg::KIND_LOAD + 1), 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(3'(sdr_pkg::KIND_LOAD + 2), 16'h1234, 16'h5678, 16'h0000);
		send_request(3'(sdr_pkg::KIND_LOAD + 3), 16'h0000, 16'h0000, 16'h8000);
		drain();

		// find a second seed and seed whose mix is the lone negative magnitude
		found = 1'b0;
		pivot_second = 16'h0001;
		pivot_seed = '0;
		for (int t = 1; t < 64 && !found; t++) begin
			for (int s = 0; s < 65536 && !found; s++) begin
				if (sb.mix(16'(s), 16'(t)) == 16'h8000) begin
					found = 1'b1;
					pivot_second = 16'(t);
					pivot_seed = 16'(s);
				end
			end
		end
		write_second_seed(pivot_second);
		send_request(sdr_pkg::KIND_LOAD, pivot_seed, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DRAW, 16'd7, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_LOAD, pivot_seed, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DRAW, 16'h8000, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_LOAD, pivot_seed, 16'h0000, 16'h0000);
		send_request(sdr_pkg::KIND_DICE, 16'd2, 16'd5, 16'h0000);
		drain();

		phase_seed = '{16'hFFFF, 16'h8000, 16'($urandom), 16'h0001, 16'($urandom), 16'h0000};
		foreach (phase_seed[p]) begin
			write_second_seed(phase_seed[p]);
			req_idle_on = (p % 3 != 2);
			rsp_idle_on = (p % 3 != 1);
			repeat (200) send_random();
			drain();
		end

		// hold both sides busy to the end
		req_idle_on = 1'b0;
		rsp_idle_on = 1'b0;
		write_second_seed(16'($urandom));
		repeat (100) send_random();
		drain();
		repeat (40) @(posedge clk);

		if (sb.expected_values.size() != 0)
			sb.report($sformatf("%0d values never returned", sb.expected_values.size()));
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hdl/sdr_pkg.sv
hdl/seeded_dice_roller.sv
sim/tb_seeded_dice_roller.sv
